>>> src/imns_pkg.sv
// ----------------------------------------------------------------------------
// imns_pkg: shared constants
// Command and status codes and fixed field widths of the interrupt mask
// nesting stack.
// ----------------------------------------------------------------------------
package imns_pkg;

    // Fixed field widths of one input item and one result item.
    localparam int CORE_W  = 2;
    localparam int MASK_W  = 8;
    localparam int DEPTH_W = 9;
    localparam int STAT_W  = 2;

    // Packed widths of the stream data words, rounded up to whole bytes.
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    // Mask value after reset: nothing masked.
    localparam logic [MASK_W-1:0] MASK_RESET = 8'd255;

    // Command codes carried in tuser.
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Status codes of a result item.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

endpackage

>>> src/imns_stack_mem.sv
// ----------------------------------------------------------------------------
// imns_stack_mem: saved mask memory
// Single write port, single read port; the read data is registered, so it
// appears in the cycle after the read is issued.
// ----------------------------------------------------------------------------
module imns_stack_mem #(
    parameter int ADDR_W = 10
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [ADDR_W-1:0]            i_waddr,
    input  logic [imns_pkg::MASK_W-1:0]  i_wdata,
    input  logic                         i_re,
    input  logic [ADDR_W-1:0]            i_raddr,
    output logic [imns_pkg::MASK_W-1:0]  o_rdata
);

    logic [imns_pkg::MASK_W-1:0] r_mem [2**ADDR_W];
    logic [imns_pkg::MASK_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/interrupt_mask_nest_stack_core.sv
// ----------------------------------------------------------------------------
// interrupt_mask_nest_stack_core: per-core interrupt mask nesting stack
// Each core keeps a priority mask and a stack of saved masks held in one
// synchronous memory. A push saves the mask and lowers it to the level if that is lower; a pop restores it.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake               Payload
// s        in         i_s_tvalid/o_s_tready   tuser command, tdata core, level
// m        out        o_m_tvalid/i_m_tready   tdata status, mask_now, suspend_os,
//                                             resume_os, nest_depth
//
// A push is handled in S_IDLE; a pop that succeeds also passes through S_POP,
// as it waits for the registered read of the saved mask memory. Every other
// item is handled in S_IDLE. A result waits in an output register; a new item
// is taken in the cycle that the register is emptied. A synchronous reset clears
// the depths and sets the masks to MASK_RESET; memory is undefined until written.
// ----------------------------------------------------------------------------
module interrupt_mask_nest_stack_core #(
    parameter int CORES      = 4,
    parameter int NEST_DEPTH = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // tdata: core [1:0], level [9:2], zero fill [15:10]
    input  logic [imns_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // tuser: command [0]
    input  logic                             i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // tdata: status [1:0], mask_now [9:2], suspend_os [10], resume_os [11],
    //        nest_depth [20:12], zero fill [23:21]
    output logic [imns_pkg::OUT_DATA_W-1:0]  o_m_tdata
);

    localparam int CW     = (CORES > 1) ? $clog2(CORES) : 1;
    localparam int DW     = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int SDW    = $clog2(NEST_DEPTH + 1);
    localparam int ADDR_W = CW + DW;

    typedef enum logic {
        S_IDLE,
        S_POP
    } t_state;

    t_state                         r_state;
    logic [SDW-1:0]                 r_depth [CORES];
    logic [imns_pkg::MASK_W-1:0]    r_mask  [CORES];
    logic [CW-1:0]                  r_pop_core;
    logic [SDW-1:0]                 r_pop_depth;

    logic                           r_out_valid;
    logic                           n_out_valid;
    logic [imns_pkg::STAT_W-1:0]    r_o_status;
    logic [imns_pkg::MASK_W-1:0]    r_o_mask;
    logic                           r_o_sus;
    logic                           r_o_res;
    logic [imns_pkg::DEPTH_W-1:0]   r_o_depth;

    logic [imns_pkg::CORE_W-1:0]    w_core;
    logic [imns_pkg::MASK_W-1:0]    w_level;
    logic [CW-1:0]                  w_idx;
    logic                           w_core_ok;
    logic                           w_accept;
    logic                           w_out_free;
    logic [SDW-1:0]                 w_cur_depth;
    logic [imns_pkg::MASK_W-1:0]    w_cur_mask;
    logic                           w_full;
    logic                           w_empty;
    logic                           w_push_ok;
    logic                           w_pop_ok;
    logic [SDW-1:0]                 n_push_depth;
    logic [SDW-1:0]                 n_pop_depth;
    logic [imns_pkg::MASK_W-1:0]    n_push_mask;
    logic [ADDR_W-1:0]              w_waddr;
    logic [ADDR_W-1:0]              w_raddr;
    logic [imns_pkg::MASK_W-1:0]    w_rdata;

    // Unpack the input item.
    assign w_core  = i_s_tdata[imns_pkg::CORE_W-1:0];
    assign w_level = i_s_tdata[imns_pkg::CORE_W +: imns_pkg::MASK_W];
    assign w_idx   = w_core[CW-1:0];
    assign w_core_ok = (32'(w_core) < CORES);

    // Handshake: one item at a time, output register free or draining.
    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Current state of the addressed core.
    always_comb begin
        w_cur_depth = '0;
        w_cur_mask  = '0;
        if (w_core_ok) begin
            w_cur_depth = r_depth[w_idx];
            w_cur_mask  = r_mask[w_idx];
        end
    end

    assign w_full    = (32'(w_cur_depth) >= NEST_DEPTH);
    assign w_empty   = (w_cur_depth == '0);
    assign w_push_ok = w_accept && w_core_ok && (i_s_tuser == imns_pkg::CMD_PUSH) && !w_full;
    assign w_pop_ok  = w_accept && w_core_ok && (i_s_tuser == imns_pkg::CMD_POP) && !w_empty;

    assign n_push_depth = w_cur_depth + SDW'(1);
    assign n_pop_depth  = w_cur_depth - SDW'(1);
    assign n_push_mask  = (w_level < w_cur_mask) ? w_level : w_cur_mask;

    // The push writes the slot at the current depth, the pop reads the one below.
    assign w_waddr = {w_idx, w_cur_depth[DW-1:0]};
    assign w_raddr = {w_idx, n_pop_depth[DW-1:0]};

    // Output register: loaded when an item finishes, emptied when taken.
    always_comb begin
        n_out_valid = r_out_valid && !i_m_tready;
        if ((r_state == S_POP) || (w_accept && !w_pop_ok)) begin
            n_out_valid = 1'b1;
        end
    end

    imns_stack_mem #(
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_push_ok),
        .i_waddr (w_waddr),
        .i_wdata (w_cur_mask),
        .i_re    (w_pop_ok),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Control state, per-core registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CORES; c++) begin
                r_depth[c] <= '0;
                r_mask[c]  <= imns_pkg::MASK_RESET;
            end
        end else begin
            r_out_valid <= n_out_valid;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (!w_core_ok) begin
                            r_o_status  <= imns_pkg::ST_OK;
                            r_o_mask    <= '0;
                            r_o_sus     <= 1'b0;
                            r_o_res     <= 1'b0;
                            r_o_depth   <= '0;
                        end else if (i_s_tuser == imns_pkg::CMD_PUSH) begin
                            r_o_res     <= 1'b0;
                            if (w_full) begin
                                r_o_status <= imns_pkg::ST_FULL;
                                r_o_mask   <= w_cur_mask;
                                r_o_sus    <= 1'b0;
                                r_o_depth  <= imns_pkg::DEPTH_W'(w_cur_depth);
                            end else begin
                                r_depth[w_idx] <= n_push_depth;
                                r_mask[w_idx]  <= n_push_mask;
                                r_o_status     <= imns_pkg::ST_OK;
                                r_o_mask       <= n_push_mask;
                                r_o_sus        <= w_empty;
                                r_o_depth      <= imns_pkg::DEPTH_W'(n_push_depth);
                            end
                        end else if (w_empty) begin
                            r_o_status  <= imns_pkg::ST_EMPTY;
                            r_o_mask    <= w_cur_mask;
                            r_o_sus     <= 1'b0;
                            r_o_res     <= 1'b0;
                            r_o_depth   <= '0;
                        end else begin
                            // Wait in S_POP for the saved mask.
                            r_state     <= S_POP;
                            r_pop_core  <= w_idx;
                            r_pop_depth <= n_pop_depth;
                        end
                    end
                end
                S_POP: begin
                    r_state             <= S_IDLE;
                    r_depth[r_pop_core] <= r_pop_depth;
                    r_mask[r_pop_core]  <= w_rdata;
                    r_o_status          <= imns_pkg::ST_OK;
                    r_o_mask            <= w_rdata;
                    r_o_sus             <= 1'b0;
                    r_o_res             <= (r_pop_depth == '0);
                    r_o_depth           <= imns_pkg::DEPTH_W'(r_pop_depth);
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Pack the result item.
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_o_depth, r_o_res, r_o_sus, r_o_mask, r_o_status};

    // A finishing pop always finds the output register empty.
    a_pop_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> !r_out_valid)
        else $error("pop completes while a result is still held");

    // A refused push reports a full stack.
    a_full_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_status == imns_pkg::ST_FULL) |->
        (32'(r_o_depth) == NEST_DEPTH))
        else $error("push refused below full depth");

    // The first push leaves exactly one saved mask.
    a_suspend_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_sus) |->
        (r_o_depth == imns_pkg::DEPTH_W'(1) && r_o_status == imns_pkg::ST_OK))
        else $error("suspend pulse without first push");

    // The last pop leaves the stack empty.
    a_resume_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_res) |-> (r_o_depth == '0 && !r_o_sus))
        else $error("resume pulse with a non-empty stack");

    // A successful pop moves to S_POP, with the input not ready, in the following cycle.
    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop_ok |=> (r_state == S_POP && !o_s_tready))
        else $error("pop did not wait for the saved mask");

endmodule
